// ===== rtl/lzr_pkg.sv =====
// shared constants and types for the lzss ring decompressor
package lzr_pkg;

    localparam int unsigned RING_DEPTH_DEF = 4096;
    localparam int unsigned RING_START     = 12'hFEE;
    localparam int unsigned MATCH_BIAS     = 3;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned LEN_W          = 32;
    localparam int unsigned REMAIN_W       = 5;
    localparam int unsigned FLAG_LEFT_W    = 4;
    localparam int unsigned FLAGS_PER_BYTE = 8;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

endpackage

// ===== rtl/lzr_ring_ram.sv =====
// dictionary ring memory: one write port, one registered read port
module lzr_ring_ram #(
    parameter int unsigned DEPTH  = lzr_pkg::RING_DEPTH_DEF,
    parameter int unsigned DATA_W = lzr_pkg::BYTE_W,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // read-first: a read at the address written in the same cycle sees old data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lzss_ring_decompressor.sv =====
// top level of the lzss ring decompressor: stream parser, copy engine, output register
//
// Compressed bytes arrive one per transaction on the s_axis side; decoded bytes leave one
// per transaction on the m_axis side, tlast marking the last byte caused by an input byte
// and tuser marking the byte that brings the output count to the configured length.
// Flag bytes, literal bytes and first match bytes are taken while the block is idle. The
// second byte of a match starts a copy of 3 to 18 bytes, one copied byte per cycle while
// the output is not stalled, with no input taken until it ends; every copied byte comes
// through the single registered read port of the ring memory, and a read that hits the
// address being written is forwarded. A stalled output holds the engine in place.
// The ring memory is never swept: a count of bytes written since the start of the
// stream tells which entries hold data, and entries not yet written read as zero, so
// the block is ready straight after reset and after the end of a stream.
// The out_length register may be written at any time the block is idle.
module lzss_ring_decompressor #(
    parameter int unsigned RING_DEPTH = lzr_pkg::RING_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write channel: out_length
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [lzr_pkg::LEN_W-1:0] i_cfg_data,
    // compressed stream in
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [7:0] in_byte
    input  logic                      s_axis_tlast,  // last_in
    // decompressed stream out
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [7:0] out_byte
    output logic                      m_axis_tlast,  // run_last
    output logic                      m_axis_tuser   // [0] length_reached
);

    localparam int unsigned AW  = $clog2(RING_DEPTH);
    localparam int unsigned BW  = lzr_pkg::BYTE_W;
    localparam int unsigned LW  = lzr_pkg::LEN_W;
    localparam int unsigned RW  = lzr_pkg::REMAIN_W;
    localparam int unsigned FLW = lzr_pkg::FLAG_LEFT_W;

    localparam logic [AW-1:0] START_POS = AW'(lzr_pkg::RING_START);

    // registers
    lzr_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_out_length, n_out_length;
    logic [BW-1:0]   r_flag_bits, n_flag_bits;
    logic [FLW-1:0]  r_flag_left, n_flag_left;
    logic [BW-1:0]   r_match_low, n_match_low;
    logic            r_await, n_await;
    logic [AW-1:0]   r_wpos, n_wpos;
    logic [LW-1:0]   r_bytes_out, n_bytes_out;
    logic [AW-1:0]   r_src, n_src;
    logic [RW-1:0]   r_remain, n_remain;
    logic            r_fwd, n_fwd;
    logic [BW-1:0]   r_fwd_data, n_fwd_data;
    logic            r_rd_ok, n_rd_ok;
    logic            r_last_pend, n_last_pend;
    logic            r_o_valid, n_o_valid;
    logic [BW-1:0]   r_o_data, n_o_data;
    logic            r_o_last, n_o_last;
    logic            r_o_user, n_o_user;

    // ring memory ports
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [BW-1:0] w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [BW-1:0] w_rd_data;

    // shared combinational terms
    logic          w_slot_free;
    logic          w_in_acc;
    logic          w_active;
    logic          w_start_copy;
    logic [BW-1:0] w_copy_data;
    logic [LW-1:0] w_next_count;
    logic          w_done;
    logic [AW-1:0] w_loc;
    logic [RW-1:0] w_len;

    lzr_ring_ram #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (BW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // entry holds data once written since the stream began: region from the start
    // position forward, as long as the byte count, or every entry once it reaches the depth
    function automatic logic f_written(logic [AW-1:0] addr, logic [LW-1:0] count);
        logic [AW-1:0] diff;
        diff = addr - START_POS;
        return (count >= LW'(RING_DEPTH)) || (LW'(diff) < count);
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign w_slot_free   = !r_o_valid || m_axis_tready;
    assign s_axis_tready = (r_state == lzr_pkg::ST_IDLE) && w_slot_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_active      = r_bytes_out < r_out_length;
    assign w_start_copy  = w_in_acc && w_active && r_await;

    // match fields from the second byte: high nibble extends the position
    assign w_loc = AW'({s_axis_tdata[7:4], r_match_low});
    assign w_len = RW'(s_axis_tdata[3:0]) + RW'(lzr_pkg::MATCH_BIAS);

    // byte being copied: forwarded write, stored entry, or zero for an unwritten entry
    assign w_copy_data  = r_fwd ? r_fwd_data : (r_rd_ok ? w_rd_data : '0);
    assign w_next_count = r_bytes_out + LW'(1);
    assign w_done       = (r_remain == RW'(1)) || (w_next_count == r_out_length);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzr_pkg::ST_IDLE: begin
                if (w_start_copy) begin
                    n_state = lzr_pkg::ST_COPY;
                end
            end
            lzr_pkg::ST_COPY: begin
                if (w_slot_free && w_done) begin
                    n_state = lzr_pkg::ST_IDLE;
                end
            end
            default: n_state = lzr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic clear;
        clear        = 1'b0;
        n_out_length = r_out_length;
        n_flag_bits  = r_flag_bits;
        n_flag_left  = r_flag_left;
        n_match_low  = r_match_low;
        n_await      = r_await;
        n_wpos       = r_wpos;
        n_bytes_out  = r_bytes_out;
        n_src        = r_src;
        n_remain     = r_remain;
        n_fwd        = r_fwd;
        n_fwd_data   = r_fwd_data;
        n_rd_ok      = r_rd_ok;
        n_last_pend  = r_last_pend;
        n_o_valid    = r_o_valid && !m_axis_tready;
        n_o_data     = r_o_data;
        n_o_last     = r_o_last;
        n_o_user     = r_o_user;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_wpos;
        w_wr_data    = s_axis_tdata;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_src;

        if (i_cfg_valid) begin
            n_out_length = i_cfg_data;
        end

        unique case (r_state)
            lzr_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_active) begin
                        priority if (r_await) begin
                            // second match byte: first read goes out now
                            n_await     = 1'b0;
                            n_remain    = w_len;
                            w_rd_en     = 1'b1;
                            w_rd_addr   = w_loc;
                            n_src       = w_loc + AW'(1);
                            n_rd_ok     = f_written(w_loc, r_bytes_out);
                            n_fwd       = 1'b0;
                            n_last_pend = s_axis_tlast;
                        end else if (r_flag_left == '0) begin
                            n_flag_bits = s_axis_tdata;
                            n_flag_left = FLW'(lzr_pkg::FLAGS_PER_BYTE);
                        end else if (r_flag_bits[0]) begin
                            // literal
                            n_flag_bits = r_flag_bits >> 1;
                            n_flag_left = r_flag_left - FLW'(1);
                            w_wr_en     = 1'b1;
                            n_wpos      = r_wpos + AW'(1);
                            n_bytes_out = w_next_count;
                            n_o_valid   = 1'b1;
                            n_o_data    = s_axis_tdata;
                            n_o_last    = 1'b1;
                            n_o_user    = (w_next_count == r_out_length);
                        end else begin
                            // first match byte; dropped if the stream ends here
                            n_flag_bits = r_flag_bits >> 1;
                            n_flag_left = r_flag_left - FLW'(1);
                            if (!s_axis_tlast) begin
                                n_match_low = s_axis_tdata;
                                n_await     = 1'b1;
                            end
                        end
                    end
                    if (s_axis_tlast && !w_start_copy) begin
                        clear = 1'b1;
                    end
                end
            end
            lzr_pkg::ST_COPY: begin
                if (w_slot_free) begin
                    w_wr_en     = 1'b1;
                    w_wr_data   = w_copy_data;
                    n_wpos      = r_wpos + AW'(1);
                    n_bytes_out = w_next_count;
                    n_o_valid   = 1'b1;
                    n_o_data    = w_copy_data;
                    n_o_last    = w_done;
                    n_o_user    = (w_next_count == r_out_length);
                    if (w_done) begin
                        clear = r_last_pend;
                    end else begin
                        // next read; an overlap with this write is forwarded
                        w_rd_en    = 1'b1;
                        w_rd_addr  = r_src;
                        n_src      = r_src + AW'(1);
                        n_remain   = r_remain - RW'(1);
                        n_fwd      = (r_src == r_wpos);
                        n_fwd_data = w_copy_data;
                        n_rd_ok    = f_written(r_src, r_bytes_out);
                    end
                end
            end
            default: ;
        endcase

        // end of stream: back to reset state, register kept
        if (clear) begin
            n_flag_bits = '0;
            n_flag_left = '0;
            n_match_low = '0;
            n_await     = 1'b0;
            n_wpos      = START_POS;
            n_bytes_out = '0;
            n_last_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lzr_pkg::ST_IDLE;
            r_out_length <= '0;
            r_flag_bits  <= '0;
            r_flag_left  <= '0;
            r_match_low  <= '0;
            r_await      <= 1'b0;
            r_wpos       <= START_POS;
            r_bytes_out  <= '0;
            r_src        <= '0;
            r_remain     <= '0;
            r_fwd        <= 1'b0;
            r_rd_ok      <= 1'b0;
            r_last_pend  <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_length <= n_out_length;
            r_flag_bits  <= n_flag_bits;
            r_flag_left  <= n_flag_left;
            r_match_low  <= n_match_low;
            r_await      <= n_await;
            r_wpos       <= n_wpos;
            r_bytes_out  <= n_bytes_out;
            r_src        <= n_src;
            r_remain     <= n_remain;
            r_fwd        <= n_fwd;
            r_rd_ok      <= n_rd_ok;
            r_last_pend  <= n_last_pend;
            r_o_valid    <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fwd_data <= n_fwd_data;
        r_o_data   <= n_o_data;
        r_o_last   <= n_o_last;
        r_o_user   <= n_o_user;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_user;

endmodule
